// ===== src/tsch_pkg.sv =====
// ----------------------------------------------------------------------------
// tsch_pkg: shared types and constants of the task scheduler
// Words of both channels, one table entry, cell and head-unit controls.
// ----------------------------------------------------------------------------
`default_nettype none

package tsch_pkg;

  localparam int unsigned CAP_W  = 20;
  localparam int unsigned NEED_W = 21;
  localparam int unsigned SUM_W  = 22;
  localparam int unsigned LEFT_W = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 20'd2048;

  typedef struct packed {
    logic        mode;
    logic [7:0]  model_tag;
    logic [15:0] task_id;
    logic [10:0] threads_per_block;
    logic [9:0]  block_count;
    logic [15:0] run_time;
    logic        has_pages;
  } in_word_t;

  typedef struct packed {
    logic              status;
    logic [7:0]        done_model_tag;
    logic [15:0]       done_task_id;
    logic              to_victim;
    logic              last;
    logic [LEFT_W-1:0] tasks_left;
  } out_word_t;

  // load is kept as threads * blocks, worked out once on insert
  typedef struct packed {
    logic [7:0]        model_tag;
    logic [15:0]       task_id;
    logic [NEED_W-1:0] need;
    logic [15:0]       run_time;
    logic              has_pages;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic head;
    logic shift;
  } cell_sel_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic admit_pass;
  } head_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== src/capacity_limited_task_scheduler.sv =====
// Insert: no result word, but a refused insert leaves one word next cycle.
// Tick over N held tasks: an admission walk over all N, then, if any task finished, an
// emit and compaction walk that waits while out is stalled. Unless held, the chain of
// TABLE_DEPTH cells moves one slot a cycle past one admission unit during a walk.
// Reset empties the table and sets the capacity to 2048; slot contents are not cleared.
// ----------------------------------------------------------------------------
// capacity_limited_task_scheduler: arrival-ordered task table with capacity
// Inserts, runs tasks per tick under a load limit, reports finished and refused ones.
// ----------------------------------------------------------------------------
`default_nettype none

module capacity_limited_task_scheduler #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire tsch_pkg::in_word_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output tsch_pkg::out_word_t               out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tsch_pkg::CAP_W-1:0]   cfg_data
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  tsch_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           k_r, k_nxt;
  logic [CNT_W-1:0]           nfin_r, nfin_nxt;
  logic [CNT_W-1:0]           emit_r, emit_nxt;
  logic [IDX_W-1:0]           tail_r, tail_nxt;
  logic [tsch_pkg::CAP_W-1:0] cap_r, cap_nxt;
  tsch_pkg::out_word_t        out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic                 in_fire;
  logic                 out_free;
  logic                 ins_we;
  logic                 reject;
  logic                 start;
  logic                 step_en;
  logic                 keep;
  logic                 emit_fire;
  logic                 walk_end;
  tsch_pkg::entry_t     ins_entry;
  tsch_pkg::entry_t     head_out;
  logic                 head_fin;
  tsch_pkg::head_ctrl_t head_ctrl;
  tsch_pkg::entry_t     cells [TABLE_DEPTH];
  tsch_pkg::cell_sel_t  sel [TABLE_DEPTH];

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == tsch_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign walk_end  = (k_r == count_r - CNT_W'(1));

  assign ins_entry.model_tag = in_data.model_tag;
  assign ins_entry.task_id   = in_data.task_id;
  assign ins_entry.need      = tsch_pkg::NEED_W'(in_data.threads_per_block) *
                               tsch_pkg::NEED_W'(in_data.block_count);
  assign ins_entry.run_time  = in_data.run_time;
  assign ins_entry.has_pages = in_data.has_pages;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsch_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tsch_pkg::ST_RUN;
        end
      end
      tsch_pkg::ST_RUN: begin
        if (walk_end) begin
          state_nxt = (nfin_nxt == '0) ? tsch_pkg::ST_IDLE : tsch_pkg::ST_EMIT;
        end
      end
      tsch_pkg::ST_EMIT: begin
        if (step_en && walk_end) begin
          state_nxt = tsch_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsch_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    start     = 1'b0;
    ins_we    = 1'b0;
    reject    = 1'b0;
    step_en   = 1'b0;
    keep      = 1'b0;
    emit_fire = 1'b0;
    head_ctrl = '0;
    count_nxt = count_r;
    k_nxt     = k_r;
    nfin_nxt  = nfin_r;
    emit_nxt  = emit_r;
    tail_nxt  = tail_r;
    unique case (state_r)
      tsch_pkg::ST_IDLE: begin
        if (in_fire && (in_data.mode == tsch_pkg::MODE_INSERT)) begin
          if (count_r < CNT_W'(TABLE_DEPTH)) begin
            ins_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            reject = 1'b1;
          end
        end else if (in_fire && (count_r != '0)) begin
          start           = 1'b1;
          head_ctrl.clear = 1'b1;
          k_nxt           = '0;
          nfin_nxt        = '0;
          tail_nxt        = IDX_W'(count_r - CNT_W'(1));
        end
      end
      tsch_pkg::ST_RUN: begin
        step_en              = 1'b1;
        keep                 = 1'b1;
        head_ctrl.step       = 1'b1;
        head_ctrl.admit_pass = 1'b1;
        nfin_nxt             = nfin_r + CNT_W'(head_fin);
        k_nxt                = k_r + CNT_W'(1);
        if (walk_end) begin
          k_nxt    = '0;
          emit_nxt = '0;
        end
      end
      tsch_pkg::ST_EMIT: begin
        // hold the walk while a finished task cannot leave
        step_en   = !head_fin || out_free;
        keep      = !head_fin;
        emit_fire = head_fin && out_free;
        if (step_en) begin
          k_nxt = k_r + CNT_W'(1);
          if (head_fin) begin
            tail_nxt = tail_r - IDX_W'(1);
            emit_nxt = emit_r + CNT_W'(1);
          end
          if (walk_end) begin
            count_nxt = count_r - nfin_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (reject) begin
      out_valid_nxt          = 1'b1;
      out_nxt.status         = tsch_pkg::STATUS_FULL;
      out_nxt.done_model_tag = in_data.model_tag;
      out_nxt.done_task_id   = in_data.task_id;
      out_nxt.to_victim      = 1'b0;
      out_nxt.last           = 1'b1;
      out_nxt.tasks_left     = tsch_pkg::LEFT_W'(count_r);
    end else if (emit_fire) begin
      out_valid_nxt          = 1'b1;
      out_nxt.status         = tsch_pkg::STATUS_DONE;
      out_nxt.done_model_tag = cells[0].model_tag;
      out_nxt.done_task_id   = cells[0].task_id;
      out_nxt.to_victim      = cells[0].has_pages;
      out_nxt.last           = (emit_r + CNT_W'(1) == nfin_r);
      out_nxt.tasks_left     = tsch_pkg::LEFT_W'(count_r - nfin_r);
    end
  end

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsch_pkg::ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      nfin_r      <= '0;
      emit_r      <= '0;
      tail_r      <= '0;
      cap_r       <= tsch_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      nfin_r      <= nfin_nxt;
      emit_r      <= emit_nxt;
      tail_r      <= tail_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  tsch_head u_head (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (head_ctrl),
    .head_in  (cells[0]),
    .cap      (cap_r),
    .head_out (head_out),
    .fin      (head_fin)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tsch_pkg::entry_t right;

    assign sel[i].ins   = ins_we && (count_r[IDX_W-1:0] == IDX_W'(i));
    assign sel[i].head  = step_en && keep && (tail_r == IDX_W'(i));
    assign sel[i].shift = step_en;

    if (i == TABLE_DEPTH - 1) begin : g_end
      assign right = cells[i];
    end else begin : g_mid
      assign right = cells[i+1];
    end

    tsch_cell u_cell (
      .clk         (clk),
      .sel         (sel[i]),
      .ins_entry   (ins_entry),
      .head_entry  (head_out),
      .right_entry (right),
      .entry       (cells[i])
    );
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("task count beyond table depth");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tsch_pkg::ST_IDLE) |-> (count_r != '0))
    else $error("walk running over an empty table");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> (emit_r < nfin_r))
    else $error("more finished words than finished tasks");

  a_emit_all: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsch_pkg::ST_EMIT && step_en && walk_end) |->
      (emit_r + CNT_W'(emit_fire) == nfin_r))
    else $error("emit walk ended with finished tasks unreported");

  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (!in_ready && state_r == tsch_pkg::ST_RUN))
    else $error("input taken while a tick walk runs");

endmodule

`default_nettype wire

// ===== src/tsch_cell.sv =====
// ----------------------------------------------------------------------------
// tsch_cell: one table slot of the task chain
// Loads a new task, a word from the head unit, or its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module tsch_cell (
  input  wire logic                clk,
  input  wire tsch_pkg::cell_sel_t sel,
  input  wire tsch_pkg::entry_t    ins_entry,
  input  wire tsch_pkg::entry_t    head_entry,
  input  wire tsch_pkg::entry_t    right_entry,
  output tsch_pkg::entry_t         entry
);

  tsch_pkg::entry_t entry_r;
  tsch_pkg::entry_t entry_nxt;

  always_comb begin
    priority if (sel.ins) begin
      entry_nxt = ins_entry;
    end else if (sel.head) begin
      entry_nxt = head_entry;
    end else if (sel.shift) begin
      entry_nxt = right_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== src/tsch_head.sv =====
// ----------------------------------------------------------------------------
// tsch_head: admission unit at the head of the chain
// Admits the head task against the tick's running load and counts it down.
// ----------------------------------------------------------------------------
`default_nettype none

module tsch_head (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tsch_pkg::head_ctrl_t           ctrl,
  input  wire tsch_pkg::entry_t               head_in,
  input  wire logic [tsch_pkg::CAP_W-1:0]     cap,
  output tsch_pkg::entry_t                    head_out,
  output logic                                fin
);

  logic [tsch_pkg::CAP_W-1:0] load_r;
  logic [tsch_pkg::CAP_W-1:0] load_nxt;
  logic [tsch_pkg::SUM_W-1:0] sum;
  logic                       admit;

  assign sum   = tsch_pkg::SUM_W'(load_r) + tsch_pkg::SUM_W'(head_in.need);
  assign admit = ctrl.admit_pass && (head_in.run_time != 16'd0) &&
                 (sum <= tsch_pkg::SUM_W'(cap));

  always_comb begin
    head_out = head_in;
    if (admit) begin
      head_out.run_time = head_in.run_time - 16'd1;
    end
  end

  assign fin = (head_out.run_time == 16'd0);

  // admitted load never exceeds capacity, so it fits in CAP_W bits
  always_comb begin
    priority if (ctrl.clear) begin
      load_nxt = '0;
    end else if (ctrl.step && admit) begin
      load_nxt = sum[tsch_pkg::CAP_W-1:0];
    end else begin
      load_nxt = load_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
    end else begin
      load_r <= load_nxt;
    end
  end

endmodule

`default_nettype wire
